@@ hw/rtl/assert_macros.svh @@
// Assertion helper macros for the quaternion unit.
// Each macro expects clk and rst to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define QAU_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("qau: same-cycle property failed");

// Consequent must hold in the cycle after the antecedent.
`define QAU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("qau: next-cycle property failed");

`endif

@@ hw/rtl/qau_pkg.sv @@
// Shared types and constants of the quaternion arithmetic unit.
// No dependencies; every RTL module imports this package.
package qau_pkg;

  localparam int PROD_N = 16;  // products formed per item
  localparam int MAT_N  = 9;   // non-trivial matrix entries (rows 0..2)

  typedef logic signed [31:0] word_t;

  typedef enum logic [2:0] {
    MODE_MUL    = 3'd0,
    MODE_SCALE  = 3'd1,
    MODE_CONJ   = 3'd2,
    MODE_INV    = 3'd3,
    MODE_NORM   = 3'd4,
    MODE_MAGSQ  = 3'd5,
    MODE_MAG    = 3'd6,
    MODE_MATRIX = 3'd7
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ZERO = 2'd1,
    ST_SAT  = 2'd2
  } status_t;

  typedef struct packed {
    mode_t mode;
    word_t a_w;
    word_t a_x;
    word_t a_y;
    word_t a_z;
    word_t b_w;
    word_t b_x;
    word_t b_y;
    word_t b_z;
  } in_t;

  typedef struct packed {
    word_t      res_0;
    word_t      res_1;
    word_t      res_2;
    word_t      res_3;
    logic [1:0] row;
    logic       last;
    status_t    status;
  } out_t;

  // Valid bit and operation that travel down the pipeline.
  typedef struct packed {
    logic  valid;
    mode_t mode;
  } ctl_t;

  // Work request to the root/divide unit.
  typedef struct packed {
    logic do_sqrt;
    logic do_div;
  } rd_cmd_t;

  typedef enum logic [1:0] {
    T_IDLE,
    T_ROWS,
    T_WORK
  } tail_state_t;

  typedef enum logic [1:0] {
    RD_IDLE,
    RD_SQRT,
    RD_DIV,
    RD_DONE
  } rd_state_t;

endpackage

@@ hw/rtl/quaternion_arithmetic_unit.sv @@
// Top level of the quaternion arithmetic unit (Q16.16 by default).
// Depends on qau_pkg, qau_mul, qau_sum, qau_tail and assert_macros.svh.
//
//   Channel   Ports                 Transaction when
//   command   start, busy, req      start high and busy low at the clock edge
//   result    valid, result         valid high (one cycle, no back-pressure)
//
// Pipeline: multiply, round, sum, output register; commands of the other
// modes may enter every cycle while busy is low. A matrix gives four rows on
// consecutive cycles; busy is high while the tail emits rows 1 to 3. Inverse
// runs the shifting divider (NUM_W = 32+FRAC_BITS), normalize the square-root
// unit and then the divider, magnitude the root alone; busy is high then.
// While busy, multiply, round and sum hold their data; rst is synchronous.
`include "assert_macros.svh"

module quaternion_arithmetic_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  qau_pkg::in_t  req,
  output logic          valid,
  output qau_pkg::out_t result
);
  import qau_pkg::*;

  localparam int SUM_W = 67 - FRAC_BITS;
  localparam int M_W   = 65 - FRAC_BITS;

  logic                    en;
  ctl_t                    ctl1, ctl3;
  logic signed [63:0]      prod [PROD_N];
  word_t                   a1 [4];
  word_t                   a3 [4];
  logic signed [SUM_W-1:0] vals [MAT_N];
  logic [M_W-1:0]          m;
  logic                    hold;

  assign busy = hold;
  assign en   = !hold;

  qau_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .en   (en),
    .take (start && !hold),
    .req  (req),
    .ctl  (ctl1),
    .prod (prod),
    .a    (a1)
  );

  qau_sum #(.FRAC_BITS(FRAC_BITS)) u_sum (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .ctl_in  (ctl1),
    .prod    (prod),
    .a_in    (a1),
    .ctl_out (ctl3),
    .vals    (vals),
    .m       (m),
    .a_out   (a3)
  );

  qau_tail #(.FRAC_BITS(FRAC_BITS)) u_tail (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl3),
    .vals   (vals),
    .m      (m),
    .a      (a3),
    .hold   (hold),
    .valid  (valid),
    .result (result)
  );

  // Matrix rows follow each other without gaps, in order.
  `QAU_ASSERT_NEXT(a_rows_in_order, valid && !result.last,
                   valid && result.row == $past(result.row) + 2'd1)
  // A zero-magnitude error carries an all-zero quaternion.
  `QAU_ASSERT_SAME(a_zero_result, valid && result.status == ST_ZERO,
                   result.res_0 == 0 && result.res_1 == 0 &&
                   result.res_2 == 0 && result.res_3 == 0)
  // Only matrix row 3 ends a multi-row transaction.
  `QAU_ASSERT_SAME(a_last_row, valid && result.last && result.row != 2'd0, result.row == 2'd3)

endmodule

@@ hw/rtl/qau_mul.sv @@
// Stage 1: operand selection and sixteen 32x32 signed products.
// Depends on qau_pkg.
module qau_mul (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 take,
  input  qau_pkg::in_t         req,
  output qau_pkg::ctl_t        ctl,
  output logic signed [63:0]   prod [qau_pkg::PROD_N],
  output qau_pkg::word_t       a    [4]
);
  import qau_pkg::*;

  logic  valid;
  mode_t mode;
  word_t op_a [PROD_N];
  word_t op_b [PROD_N];

  assign ctl = '{valid: valid, mode: mode};

  // Pick the operand pairs that each mode needs.
  always_comb begin
    for (int i = 0; i < PROD_N; i++) begin
      op_a[i] = '0;
      op_b[i] = '0;
    end
    case (req.mode)
      MODE_MUL: begin
        op_a[0]  = req.a_w; op_b[0]  = req.b_w;
        op_a[1]  = req.a_x; op_b[1]  = req.b_x;
        op_a[2]  = req.a_y; op_b[2]  = req.b_y;
        op_a[3]  = req.a_z; op_b[3]  = req.b_z;
        op_a[4]  = req.a_w; op_b[4]  = req.b_x;
        op_a[5]  = req.a_x; op_b[5]  = req.b_w;
        op_a[6]  = req.a_y; op_b[6]  = req.b_z;
        op_a[7]  = req.a_z; op_b[7]  = req.b_y;
        op_a[8]  = req.a_w; op_b[8]  = req.b_y;
        op_a[9]  = req.a_x; op_b[9]  = req.b_z;
        op_a[10] = req.a_y; op_b[10] = req.b_w;
        op_a[11] = req.a_z; op_b[11] = req.b_x;
        op_a[12] = req.a_w; op_b[12] = req.b_z;
        op_a[13] = req.a_x; op_b[13] = req.b_y;
        op_a[14] = req.a_y; op_b[14] = req.b_x;
        op_a[15] = req.a_z; op_b[15] = req.b_w;
      end
      MODE_SCALE: begin
        op_a[0] = req.a_w; op_b[0] = req.b_w;
        op_a[1] = req.a_x; op_b[1] = req.b_w;
        op_a[2] = req.a_y; op_b[2] = req.b_w;
        op_a[3] = req.a_z; op_b[3] = req.b_w;
      end
      default: begin
        // Squares for the magnitude, cross terms for the matrix.
        op_a[0] = req.a_w; op_b[0] = req.a_w;
        op_a[1] = req.a_x; op_b[1] = req.a_x;
        op_a[2] = req.a_y; op_b[2] = req.a_y;
        op_a[3] = req.a_z; op_b[3] = req.a_z;
        op_a[4] = req.a_x; op_b[4] = req.a_y;
        op_a[5] = req.a_x; op_b[5] = req.a_z;
        op_a[6] = req.a_y; op_b[6] = req.a_z;
        op_a[7] = req.a_x; op_b[7] = req.a_w;
        op_a[8] = req.a_y; op_b[8] = req.a_w;
        op_a[9] = req.a_z; op_b[9] = req.a_w;
      end
    endcase
  end

  // Valid bit of the stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= take;
    end
  end

  // Product registers.
  always_ff @(posedge clk) begin
    if (en) begin
      mode <= req.mode;
      a[0] <= req.a_w;
      a[1] <= req.a_x;
      a[2] <= req.a_y;
      a[3] <= req.a_z;
      for (int i = 0; i < PROD_N; i++) begin
        prod[i] <= op_a[i] * op_b[i];
      end
    end
  end

endmodule

@@ hw/rtl/qau_sum.sv @@
// Stages 2 and 3: rounding of the products, then the sums of each mode.
// Depends on qau_pkg.
module qau_sum #(
  parameter  int FRAC_BITS = 16,
  localparam int SUM_W     = 67 - FRAC_BITS,
  localparam int M_W       = 65 - FRAC_BITS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  qau_pkg::ctl_t           ctl_in,
  input  logic signed [63:0]      prod [qau_pkg::PROD_N],
  input  qau_pkg::word_t          a_in [4],
  output qau_pkg::ctl_t           ctl_out,
  output logic signed [SUM_W-1:0] vals [qau_pkg::MAT_N],
  output logic [M_W-1:0]          m,
  output qau_pkg::word_t          a_out [4]
);
  import qau_pkg::*;

  localparam int RP_W = 64 - FRAC_BITS;
  localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [SUM_W-1:0] ONE = SUM_W'(64'sd1 <<< FRAC_BITS);

  logic                    valid1, valid2;
  mode_t                   mode1, mode2;
  logic signed [RP_W-1:0]  rp      [PROD_N];
  logic signed [RP_W-1:0]  rp_next [PROD_N];
  word_t                   a1 [4];
  logic signed [SUM_W-1:0] e [PROD_N];
  logic signed [SUM_W-1:0] m_full;
  logic signed [SUM_W-1:0] vals_next [MAT_N];

  assign ctl_out = '{valid: valid2, mode: mode2};

  // Round each product to nearest, ties upward.
  always_comb begin
    for (int i = 0; i < PROD_N; i++) begin
      rp_next[i] = RP_W'((prod[i] + HALF) >>> FRAC_BITS);
    end
  end

  // Sums and matrix entries.
  always_comb begin
    for (int i = 0; i < PROD_N; i++) begin
      e[i] = SUM_W'(rp[i]);
    end
    for (int i = 0; i < MAT_N; i++) begin
      vals_next[i] = '0;
    end
    m_full = e[0] + e[1] + e[2] + e[3];
    case (mode1)
      MODE_MUL: begin
        vals_next[0] = e[0] - e[1] - e[2] - e[3];
        vals_next[1] = e[4] + e[5] + e[6] - e[7];
        vals_next[2] = e[8] - e[9] + e[10] + e[11];
        vals_next[3] = e[12] + e[13] - e[14] + e[15];
      end
      MODE_SCALE: begin
        for (int i = 0; i < 4; i++) begin
          vals_next[i] = e[i];
        end
      end
      MODE_CONJ: begin
        vals_next[0] = SUM_W'(a1[0]);
        vals_next[1] = -SUM_W'(a1[1]);
        vals_next[2] = -SUM_W'(a1[2]);
        vals_next[3] = -SUM_W'(a1[3]);
      end
      MODE_MATRIX: begin
        // e1..e3 squares, e4 xy, e5 xz, e6 yz, e7 wx, e8 wy, e9 wz.
        vals_next[0] = ONE - 2 * e[2] - 2 * e[3];
        vals_next[1] = 2 * e[4] - 2 * e[9];
        vals_next[2] = 2 * e[5] + 2 * e[8];
        vals_next[3] = 2 * e[4] + 2 * e[9];
        vals_next[4] = ONE - 2 * e[1] - 2 * e[3];
        vals_next[5] = 2 * e[6] - 2 * e[7];
        vals_next[6] = 2 * e[5] - 2 * e[8];
        vals_next[7] = 2 * e[6] + 2 * e[7];
        vals_next[8] = ONE - 2 * e[1] - 2 * e[2];
      end
      default: begin
        vals_next[0] = m_full;
      end
    endcase
  end

  // Valid bits of both stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
      valid2 <= 1'b0;
    end else if (en) begin
      valid1 <= ctl_in.valid;
      valid2 <= valid1;
    end
  end

  // Stage payload registers.
  always_ff @(posedge clk) begin
    if (en) begin
      mode1 <= ctl_in.mode;
      mode2 <= mode1;
      a1    <= a_in;
      a_out <= a1;
      rp    <= rp_next;
      vals  <= vals_next;
      m     <= m_full[M_W-1:0];
    end
  end

endmodule

@@ hw/rtl/qau_root_div.sv @@
// Iterative square root (two radicand bits a cycle) and four-lane
// restoring divider (one quotient bit a cycle). Depends on qau_pkg.
module qau_root_div #(
  parameter  int FRAC_BITS = 16,
  localparam int M_W       = 65 - FRAC_BITS,
  localparam int NUM_W     = 32 + FRAC_BITS,
  localparam int RES_W     = NUM_W + 1
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  qau_pkg::rd_cmd_t        cmd,
  input  logic [M_W-1:0]          m,
  input  logic [31:0]             mag [4],
  input  logic                    neg [4],
  output logic                    done,
  output logic signed [RES_W-1:0] res [4]
);
  import qau_pkg::*;

  localparam int CNT_W = $clog2(NUM_W);
  localparam logic [32:0] ROOT_OVF = 33'h1_0000_0000;

  rd_state_t        state, state_next;
  logic [CNT_W-1:0] cnt;
  rd_cmd_t          op;
  logic [63:0]      rad;
  logic [34:0]      rem_s;
  logic [32:0]      root;
  logic [34:0]      cat, trial;
  logic [34:0]      rem_s_next;
  logic [32:0]      root_next;
  logic [M_W-1:0]   den;
  logic [NUM_W-1:0] num [4];
  logic [NUM_W-1:0] q   [4];
  logic [M_W:0]     rem [4];
  logic [M_W:0]     sh  [4];
  logic             ge  [4];
  logic             sgn [4];
  logic             ovf;

  assign ovf  = m[M_W-1];
  assign done = (state == RD_DONE);

  // One square-root step.
  always_comb begin
    cat   = {rem_s[32:0], rad[63:62]};
    trial = {1'b0, root[31:0], 2'b01};
    if (cat >= trial) begin
      rem_s_next = cat - trial;
      root_next  = {root[31:0], 1'b1};
    end else begin
      rem_s_next = cat;
      root_next  = {root[31:0], 1'b0};
    end
  end

  // One division step in every lane.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sh[i] = {rem[i][M_W-1:0], num[i][NUM_W-1]};
      ge[i] = (sh[i] >= {1'b0, den});
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      RD_IDLE: begin
        if (start) begin
          if (cmd.do_sqrt && !ovf) begin
            state_next = RD_SQRT;
          end else if (cmd.do_div) begin
            state_next = RD_DIV;
          end else begin
            state_next = RD_DONE;
          end
        end
      end
      RD_SQRT: begin
        if (cnt == CNT_W'(31)) begin
          state_next = op.do_div ? RD_DIV : RD_DONE;
        end
      end
      RD_DIV: begin
        if (cnt == CNT_W'(NUM_W - 1)) begin
          state_next = RD_DONE;
        end
      end
      RD_DONE: state_next = RD_IDLE;
      default: state_next = RD_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= RD_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      RD_IDLE: begin
        if (start) begin
          op    <= cmd;
          cnt   <= '0;
          rad   <= {m[63-FRAC_BITS:0], {FRAC_BITS{1'b0}}};
          rem_s <= '0;
          root  <= cmd.do_sqrt && ovf ? ROOT_OVF : '0;
          den   <= cmd.do_sqrt ? M_W'(ROOT_OVF) : m;
          for (int i = 0; i < 4; i++) begin
            num[i] <= {mag[i], {FRAC_BITS{1'b0}}};
            q[i]   <= '0;
            rem[i] <= '0;
            sgn[i] <= neg[i];
          end
        end
      end
      RD_SQRT: begin
        rem_s <= rem_s_next;
        root  <= root_next;
        rad   <= {rad[61:0], 2'b00};
        if (cnt == CNT_W'(31)) begin
          cnt <= '0;
          den <= M_W'(root_next);
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
      RD_DIV: begin
        cnt <= cnt + 1'b1;
        for (int i = 0; i < 4; i++) begin
          rem[i] <= ge[i] ? sh[i] - {1'b0, den} : sh[i];
          q[i]   <= {q[i][NUM_W-2:0], ge[i]};
          num[i] <= {num[i][NUM_W-2:0], 1'b0};
        end
      end
      default: begin
      end
    endcase
  end

  // Signed quotients, or the root alone for the magnitude.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (op.do_div) begin
        res[i] = sgn[i] ? -RES_W'(q[i]) : RES_W'(q[i]);
      end else begin
        res[i] = (i == 0) ? RES_W'(root) : '0;
      end
    end
  end

endmodule

@@ hw/rtl/qau_tail.sv @@
// Output sequencer: saturation, matrix row emission, root/divide hand-off
// and the result register. Depends on qau_pkg and qau_root_div.
module qau_tail #(
  parameter  int FRAC_BITS = 16,
  localparam int SUM_W     = 67 - FRAC_BITS,
  localparam int M_W       = 65 - FRAC_BITS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  qau_pkg::ctl_t           ctl,
  input  logic signed [SUM_W-1:0] vals [qau_pkg::MAT_N],
  input  logic [M_W-1:0]          m,
  input  qau_pkg::word_t          a [4],
  output logic                    hold,
  output logic                    valid,
  output qau_pkg::out_t           result
);
  import qau_pkg::*;

  localparam int NUM_W = 32 + FRAC_BITS;
  localparam int RES_W = NUM_W + 1;
  localparam int WIDE  = (SUM_W > RES_W) ? SUM_W : RES_W;
  localparam logic signed [WIDE-1:0] SMAX = WIDE'(64'sd2147483647);
  localparam logic signed [WIDE-1:0] SMIN = WIDE'(-64'sd2147483648);
  localparam logic signed [WIDE-1:0] WONE = WIDE'(64'sd1 <<< FRAC_BITS);

  tail_state_t             state, state_next;
  logic [1:0]              cnt, cnt_next;
  logic                    valid_next;
  out_t                    result_next;
  logic signed [SUM_W-1:0] mat [6];
  logic                    mat_load;
  logic                    rd_start, rd_done;
  rd_cmd_t                 rd_cmd;
  logic [31:0]             mag [4];
  logic                    neg [4];
  logic signed [RES_W-1:0] rd_res [4];
  logic [2:0]              base;

  function automatic logic [32:0] sat32(input logic signed [WIDE-1:0] v);
    if (v > SMAX) begin
      return {1'b1, SMAX[31:0]};
    end else if (v < SMIN) begin
      return {1'b1, SMIN[31:0]};
    end
    return {1'b0, v[31:0]};
  endfunction

  function automatic out_t pack_row(input logic signed [WIDE-1:0] v0, v1, v2, v3,
                                    input logic [1:0] r, input logic l,
                                    input status_t st);
    logic [32:0] s0, s1, s2, s3;
    out_t        o;
    s0 = sat32(v0);
    s1 = sat32(v1);
    s2 = sat32(v2);
    s3 = sat32(v3);
    o.res_0  = s0[31:0];
    o.res_1  = s1[31:0];
    o.res_2  = s2[31:0];
    o.res_3  = s3[31:0];
    o.row    = r;
    o.last   = l;
    o.status = (s0[32] | s1[32] | s2[32] | s3[32]) ? ST_SAT : st;
    return o;
  endfunction

  assign hold = (state != T_IDLE);

  // Numerators for inverse and normalize: magnitude and sign.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mag[i] = a[i][31] ? 32'(-a[i]) : 32'(a[i]);
      if (ctl.mode == MODE_INV && i != 0) begin
        neg[i] = (a[i] > 0);
      end else begin
        neg[i] = a[i][31];
      end
    end
    rd_cmd.do_sqrt = (ctl.mode == MODE_NORM) || (ctl.mode == MODE_MAG);
    rd_cmd.do_div  = (ctl.mode == MODE_NORM) || (ctl.mode == MODE_INV);
  end

  qau_root_div #(.FRAC_BITS(FRAC_BITS)) u_root_div (
    .clk   (clk),
    .rst   (rst),
    .start (rd_start),
    .cmd   (rd_cmd),
    .m     (m),
    .mag   (mag),
    .neg   (neg),
    .done  (rd_done),
    .res   (rd_res)
  );

  assign base = (cnt == 2'd2) ? 3'd3 : 3'd0;

  // Next state and the next result transaction.
  always_comb begin
    state_next  = state;
    cnt_next    = cnt;
    valid_next  = 1'b0;
    result_next = result;
    rd_start    = 1'b0;
    mat_load    = 1'b0;
    unique case (state)
      T_IDLE: begin
        if (ctl.valid) begin
          case (ctl.mode) inside
            MODE_MATRIX: begin
              valid_next  = 1'b1;
              result_next = pack_row(WIDE'(vals[0]), WIDE'(vals[1]), WIDE'(vals[2]),
                                     '0, 2'd0, 1'b0, ST_OK);
              mat_load    = 1'b1;
              cnt_next    = 2'd1;
              state_next  = T_ROWS;
            end
            MODE_INV, MODE_NORM: begin
              if (m == '0) begin
                valid_next  = 1'b1;
                result_next = pack_row('0, '0, '0, '0, 2'd0, 1'b1, ST_ZERO);
              end else begin
                rd_start   = 1'b1;
                state_next = T_WORK;
              end
            end
            MODE_MAG: begin
              rd_start   = 1'b1;
              state_next = T_WORK;
            end
            default: begin
              valid_next  = 1'b1;
              result_next = pack_row(WIDE'(vals[0]), WIDE'(vals[1]), WIDE'(vals[2]),
                                     WIDE'(vals[3]), 2'd0, 1'b1, ST_OK);
            end
          endcase
        end
      end
      T_ROWS: begin
        valid_next = 1'b1;
        if (cnt == 2'd3) begin
          result_next = pack_row('0, '0, '0, WONE, 2'd3, 1'b1, ST_OK);
          state_next  = T_IDLE;
        end else begin
          result_next = pack_row(WIDE'(mat[base]), WIDE'(mat[base + 3'd1]),
                                 WIDE'(mat[base + 3'd2]), '0, cnt, 1'b0, ST_OK);
          cnt_next    = cnt + 2'd1;
        end
      end
      T_WORK: begin
        if (rd_done) begin
          valid_next  = 1'b1;
          result_next = pack_row(WIDE'(rd_res[0]), WIDE'(rd_res[1]), WIDE'(rd_res[2]),
                                 WIDE'(rd_res[3]), 2'd0, 1'b1, ST_OK);
          state_next  = T_IDLE;
        end
      end
      default: state_next = T_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE;
      cnt   <= 2'd0;
      valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      valid <= valid_next;
    end
  end

  // Result payload and the stored matrix rows 1 and 2.
  always_ff @(posedge clk) begin
    result <= result_next;
    if (mat_load) begin
      for (int i = 0; i < 6; i++) begin
        mat[i] <= vals[i + 3];
      end
    end
  end

endmodule

@@ tb/tb_quaternion_arithmetic_unit.sv @@
// Testbench of the quaternion arithmetic unit: directed and random commands of every mode.
// Depends on qau_pkg and quaternion_arithmetic_unit; results are predicted in the bench.
module tb_quaternion_arithmetic_unit;
  import qau_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB = 16;
  localparam longint ONE = 64'sd1 << FB;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic valid;
  in_t req = '0;
  out_t result;
  out_t expected_rows[$];
  int err_count = 0;

  quaternion_arithmetic_unit #(.FRAC_BITS(FB)) u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .valid(valid), .result(result)
  );

  always #5 clk = ~clk;

  // Product of two fields rounded to nearest, ties toward +infinity.
  function automatic longint qmul(longint a, longint b);
    return (a * b + (64'sd1 << (FB - 1))) >>> FB;
  endfunction

  function automatic word_t clamp(longint v, inout bit sat);
    if (v > 64'sd2147483647) begin
      sat = 1'b1;
      return 32'sh7fffffff;
    end
    if (v < -64'sd2147483648) begin
      sat = 1'b1;
      return 32'sh80000000;
    end
    return word_t'(v);
  endfunction

  // Integer square root of a 64-bit value.
  function automatic longint unsigned root64(longint unsigned n);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic out_t pack_row(longint v[4], int r, bit lst, status_t st);
    out_t o;
    bit sat;
    sat = 1'b0;
    o.res_0 = clamp(v[0], sat);
    o.res_1 = clamp(v[1], sat);
    o.res_2 = clamp(v[2], sat);
    o.res_3 = clamp(v[3], sat);
    o.row = r[1:0];
    o.last = lst;
    o.status = sat ? ST_SAT : st;
    return o;
  endfunction

  // Expected rows of one command, queued in order.
  task automatic predict_quaternion(in_t c);
    longint aw, ax, ay, az, bw, bx, by, bz, m, s, den;
    longint v[4];
    longint cv[4];
    longint xx, yy, zz, xy, xz, yz, wx, wy, wz;
    aw = c.a_w; ax = c.a_x; ay = c.a_y; az = c.a_z;
    bw = c.b_w; bx = c.b_x; by = c.b_y; bz = c.b_z;
    v = '{0, 0, 0, 0};
    m = qmul(aw, aw) + qmul(ax, ax) + qmul(ay, ay) + qmul(az, az);
    if (m < (64'sd1 << (64 - FB))) s = longint'(root64(longint'(m) << FB));
    else s = 64'sd1 << 32;
    case (c.mode)
      MODE_MUL: begin
        v[0] = qmul(aw, bw) - qmul(ax, bx) - qmul(ay, by) - qmul(az, bz);
        v[1] = qmul(aw, bx) + qmul(ax, bw) + qmul(ay, bz) - qmul(az, by);
        v[2] = qmul(aw, by) - qmul(ax, bz) + qmul(ay, bw) + qmul(az, bx);
        v[3] = qmul(aw, bz) + qmul(ax, by) - qmul(ay, bx) + qmul(az, bw);
      end
      MODE_SCALE: v = '{qmul(aw, bw), qmul(ax, bw), qmul(ay, bw), qmul(az, bw)};
      MODE_CONJ: v = '{aw, -ax, -ay, -az};
      MODE_INV, MODE_NORM: begin
        den = (c.mode == MODE_INV) ? m : s;
        if (den <= 0) begin
          expected_rows.push_back(pack_row(v, 0, 1'b1, ST_ZERO));
          return;
        end
        if (c.mode == MODE_INV) cv = '{aw, -ax, -ay, -az};
        else cv = '{aw, ax, ay, az};
        for (int i = 0; i < 4; i++) v[i] = (cv[i] * ONE) / den;
      end
      MODE_MAGSQ: v[0] = m;
      MODE_MAG: v[0] = s;
      default: begin
        xx = qmul(ax, ax); yy = qmul(ay, ay); zz = qmul(az, az);
        xy = qmul(ax, ay); xz = qmul(ax, az); yz = qmul(ay, az);
        wx = qmul(ax, aw); wy = qmul(ay, aw); wz = qmul(az, aw);
        v = '{ONE - 2 * yy - 2 * zz, 2 * xy - 2 * wz, 2 * xz + 2 * wy, 0};
        expected_rows.push_back(pack_row(v, 0, 1'b0, ST_OK));
        v = '{2 * xy + 2 * wz, ONE - 2 * xx - 2 * zz, 2 * yz - 2 * wx, 0};
        expected_rows.push_back(pack_row(v, 1, 1'b0, ST_OK));
        v = '{2 * xz - 2 * wy, 2 * yz + 2 * wx, ONE - 2 * xx - 2 * yy, 0};
        expected_rows.push_back(pack_row(v, 2, 1'b0, ST_OK));
        v = '{0, 0, 0, ONE};
        expected_rows.push_back(pack_row(v, 3, 1'b1, ST_OK));
        return;
      end
    endcase
    expected_rows.push_back(pack_row(v, 0, 1'b1, ST_OK));
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    err_count++;
    $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
  endtask

  // Sends one command: optional gap, then hold start until accepted.
  // Without a gap, start stays high so commands follow back to back.
  task automatic send_command(in_t c, bit gaps);
    int gap;
    gap = 0;
    if (gaps) gap = ($urandom_range(9) == 0) ? $urandom_range(30, 8) : $urandom_range(2);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req <= c;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    predict_quaternion(c);
    @(negedge clk);
  endtask

  // Checks each result transaction against the oldest expectation.
  always @(posedge clk) begin
    out_t e;
    if (!rst && valid) begin
      if (expected_rows.size() == 0) begin
        report_mismatch("unexpected result", 0, 0);
      end else begin
        e = expected_rows.pop_front();
        if (result.res_0 !== e.res_0) report_mismatch("res_0", result.res_0, e.res_0);
        if (result.res_1 !== e.res_1) report_mismatch("res_1", result.res_1, e.res_1);
        if (result.res_2 !== e.res_2) report_mismatch("res_2", result.res_2, e.res_2);
        if (result.res_3 !== e.res_3) report_mismatch("res_3", result.res_3, e.res_3);
        if (result.row !== e.row) report_mismatch("row", result.row, e.row);
        if (result.last !== e.last) report_mismatch("last", result.last, e.last);
        if (result.status !== e.status) report_mismatch("status", result.status, e.status);
      end
    end
  end

  function automatic word_t rand_word();
    case ($urandom_range(5))
      0: return word_t'($urandom);
      1: return 32'sh80000000;
      2: return 32'sh7fffffff;
      3: return word_t'($urandom_range(65536 * 2)) - 32'sd65536;
      default: return word_t'(int'($urandom_range(65536)) - 32768);
    endcase
  endfunction

  function automatic in_t make_cmd(mode_t md, word_t w, word_t x, word_t y, word_t z);
    in_t c;
    c.mode = md;
    c.a_w = w; c.a_x = x; c.a_y = y; c.a_z = z;
    c.b_w = rand_word(); c.b_x = rand_word(); c.b_y = rand_word(); c.b_z = rand_word();
    return c;
  endfunction

  // Every mode on unit and on mixed minimum and maximum operands, then special cases.
  task automatic test_directed_modes();
    word_t mn, mx;
    mn = 32'sh80000000;
    mx = 32'sh7fffffff;
    for (int md = 0; md < 8; md++) begin
      send_command(make_cmd(mode_t'(md), 32'sd65536, 32'sd0, 32'sd0, 32'sd0), 1'b0);
      send_command(make_cmd(mode_t'(md), mx, mn, mx, mn), 1'b0);
    end
    // Zero magnitude in inverse and normalize.
    send_command(make_cmd(MODE_INV, 0, 0, 0, 0), 1'b0);
    send_command(make_cmd(MODE_NORM, 0, 0, 0, 0), 1'b0);
    // Tiny components whose rounded squares vanish.
    send_command(make_cmd(MODE_INV, 1, -1, 1, 0), 1'b0);
    // Conjugate of the minimum value, and magnitude overflow.
    send_command(make_cmd(MODE_CONJ, mn, mn, mx, mn), 1'b0);
    send_command(make_cmd(MODE_MAG, mn, mn, mn, mn), 1'b0);
    send_command(make_cmd(MODE_NORM, mn, mn, mn, mn), 1'b0);
  endtask

  // Random commands, in blocks with and without random gaps, matrix mode mixed in.
  task automatic test_random_stream();
    in_t c;
    for (int i = 0; i < 450; i++) begin
      c = make_cmd(mode_t'($urandom_range(7)), rand_word(), rand_word(), rand_word(),
                   rand_word());
      send_command(c, (i / 60) % 2 == 0);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed_modes();
    test_random_stream();
    start <= 1'b0;
    while (expected_rows.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_count == 0 && expected_rows.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Regression FAIL");
    $finish;
  end
endmodule
